// File: sv/sprite_affine_transform_build_macros.svh
// assertion helpers for the sprite affine block
`ifndef SPRITE_AFFINE_TRANSFORM_BUILD_MACROS_SVH
`define SPRITE_AFFINE_TRANSFORM_BUILD_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SAT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked in the cycle after the antecedent
`define SAT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/satb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package satb_pkg;
	localparam int FRAC_BITS  = 16;
	localparam int ANGLE_BITS = 16;
	localparam int PIPE_DEPTH = 11;

	localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
	localparam logic [63:0] Q30_HALF = 64'd1 << 29;
	localparam logic [31:0] SIN_C1  = 32'd1686629713;
	localparam logic [31:0] SIN_C3  = 32'd693598668;
	localparam logic [31:0] SIN_C5  = 32'd85569308;
	localparam logic [31:0] SIN_C7  = 32'd5026996;
	localparam logic [31:0] SIN_C9  = 32'd172272;
	localparam logic [31:0] SIN_C11 = 32'd3864;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic        [15:0] angle;
		logic signed [31:0] skew_x;
		logic signed [31:0] skew_y;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] pivot_x;
		logic signed [31:0] pivot_y;
		logic signed [31:0] width;
		logic signed [31:0] height;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] m_a;
		logic signed [31:0] m_b;
		logic signed [31:0] m_c;
		logic signed [31:0] m_d;
		logic signed [31:0] trans_x;
		logic signed [31:0] trans_y;
	} out_item_t;

	// round half away from zero by a shift
	function automatic logic signed [95:0] rnd(input logic signed [95:0] v, input int sh);
		logic [95:0] m;
		m = v[95] ? (~v + 96'd1) : v;
		m = (m + (96'd1 << (sh - 1))) >> sh;
		return v[95] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
		if (v > 96'sh7FFFFFFF) return 32'sh7FFFFFFF;
		if (v < -96'sh80000000) return 32'sh80000000;
		return v[31:0];
	endfunction

	// unsigned Horner step: c - rnd(u*acc)
	function automatic logic [63:0] hstep(input logic [63:0] c, input logic [31:0] u,
		input logic [31:0] acc);
		logic [63:0] p;
		p = {32'd0, u} * {32'd0, acc};
		return c - ((p + Q30_HALF) >> 30);
	endfunction
endpackage
`default_nettype wire

// File: sv/satb_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface satb_in_if;
	logic valid;
	logic ready;
	satb_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface satb_out_if;
	logic valid;
	logic ready;
	satb_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/satb_sine.sv
`timescale 1ns / 1ps
`default_nettype none
// pipelined quarter sine, seven stages, advances when en is high
module satb_sine (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] t,
	output logic      [31:0] s
);
	logic [31:0] t_s1, u_s1, t_s2, u_s2, a_s2, t_s3, u_s3, a_s3;
	logic [31:0] t_s4, u_s4, a_s4, t_s5, u_s5, a_s5, t_s6, a_s6;
	logic [63:0] sq, fin;

	always_comb begin
		sq  = {32'd0, t} * {32'd0, t};
		fin = (({32'd0, t_s6} * {32'd0, a_s6}) + satb_pkg::Q30_HALF) >> 30;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= t;
			u_s1 <= 32'((sq + satb_pkg::Q30_HALF) >> 30);
			t_s2 <= t_s1; u_s2 <= u_s1;
			a_s2 <= 32'(satb_pkg::hstep({32'd0, satb_pkg::SIN_C9}, u_s1, satb_pkg::SIN_C11));
			t_s3 <= t_s2; u_s3 <= u_s2;
			a_s3 <= 32'(satb_pkg::hstep({32'd0, satb_pkg::SIN_C7}, u_s2, a_s2));
			t_s4 <= t_s3; u_s4 <= u_s3;
			a_s4 <= 32'(satb_pkg::hstep({32'd0, satb_pkg::SIN_C5}, u_s3, a_s3));
			t_s5 <= t_s4; u_s5 <= u_s4;
			a_s5 <= 32'(satb_pkg::hstep({32'd0, satb_pkg::SIN_C3}, u_s4, a_s4));
			t_s6 <= t_s5;
			a_s6 <= 32'(satb_pkg::hstep({32'd0, satb_pkg::SIN_C1}, u_s5, a_s5));
			s    <= (fin > satb_pkg::Q30_ONE) ? 32'(satb_pkg::Q30_ONE) : fin[31:0];
		end
	end
endmodule
`default_nettype wire

// File: sv/satb_matrix.sv
`timescale 1ns / 1ps
`default_nettype none
// element stages after sine/cosine: skew combine, scale, then translation
module satb_matrix (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic signed [31:0]  sn,
	input  wire logic signed [31:0]  cs,
	input  wire satb_pkg::in_item_t  item,
	output satb_pkg::out_item_t      res
);
	localparam int F = satb_pkg::FRAC_BITS;
	logic signed [95:0] ea, eb, ec, ed;
	logic signed [33:0] ea_s1, eb_s1, ec_s1, ed_s1;
	logic signed [31:0] ox_s1, oy_s1;
	satb_pkg::in_item_t it_s1, it_s2, it_s3;
	logic signed [31:0] ma_s2, mb_s2, mc_s2, md_s2, ox_s2, oy_s2;
	logic signed [63:0] pa_s3, pb_s3, pc_s3, pd_s3;
	logic signed [31:0] ma_s3, mb_s3, mc_s3, md_s3;
	logic signed [63:0] ta_s4, ty_s4;
	logic signed [31:0] ma_s4, mb_s4, mc_s4, md_s4;

	always_comb begin
		ea = satb_pkg::rnd(96'(cs) * (96'sd1 <<< F) + 96'(-96'(sn)) * 96'(item.skew_y), 30);
		eb = satb_pkg::rnd(96'(-96'(sn)) * (96'sd1 <<< F) + 96'(cs) * 96'(item.skew_x), 30);
		ec = satb_pkg::rnd(96'(sn) * (96'sd1 <<< F) + 96'(cs) * 96'(item.skew_y), 30);
		ed = satb_pkg::rnd(96'(cs) * (96'sd1 <<< F) + 96'(sn) * 96'(item.skew_x), 30);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: rotated shear and pivot offset
			ea_s1 <= ea[33:0]; eb_s1 <= eb[33:0]; ec_s1 <= ec[33:0]; ed_s1 <= ed[33:0];
			ox_s1 <= satb_pkg::sat32(satb_pkg::rnd(96'(item.pivot_x) * 96'(item.width), F));
			oy_s1 <= satb_pkg::sat32(satb_pkg::rnd(96'(item.pivot_y) * 96'(item.height), F));
			it_s1 <= item;
			// stage 2: scale
			ma_s2 <= satb_pkg::sat32(satb_pkg::rnd(96'(ea_s1) * 96'(it_s1.scale_x), F));
			mb_s2 <= satb_pkg::sat32(satb_pkg::rnd(96'(eb_s1) * 96'(it_s1.scale_y), F));
			mc_s2 <= satb_pkg::sat32(satb_pkg::rnd(96'(ec_s1) * 96'(it_s1.scale_x), F));
			md_s2 <= satb_pkg::sat32(satb_pkg::rnd(96'(ed_s1) * 96'(it_s1.scale_y), F));
			ox_s2 <= ox_s1; oy_s2 <= oy_s1; it_s2 <= it_s1;
			// stage 3: products with offsets
			pa_s3 <= 64'(satb_pkg::rnd(96'(ma_s2) * 96'(ox_s2), F));
			pb_s3 <= 64'(satb_pkg::rnd(96'(mb_s2) * 96'(oy_s2), F));
			pc_s3 <= 64'(satb_pkg::rnd(96'(mc_s2) * 96'(ox_s2), F));
			pd_s3 <= 64'(satb_pkg::rnd(96'(md_s2) * 96'(oy_s2), F));
			ma_s3 <= ma_s2; mb_s3 <= mb_s2; mc_s3 <= mc_s2; md_s3 <= md_s2; it_s3 <= it_s2;
			// stage 4: sums
			ta_s4 <= 64'(it_s3.pos_x) - pa_s3 - pb_s3;
			ty_s4 <= 64'(it_s3.pos_y) - pc_s3 - pd_s3;
			ma_s4 <= ma_s3; mb_s4 <= mb_s3; mc_s4 <= mc_s3; md_s4 <= md_s3;
		end
	end

	always_comb begin
		res.m_a = ma_s4; res.m_b = mb_s4; res.m_c = mc_s4; res.m_d = md_s4;
		res.trans_x = satb_pkg::sat32(96'(ta_s4));
		res.trans_y = satb_pkg::sat32(96'(ty_s4));
	end
endmodule
`default_nettype wire

// File: sv/sprite_affine_transform_build.sv
// Builds one sprite's affine matrix T(pos)*R*Shear*Scale*T(-pivot*size) per transfer in
// Q16.16 with saturation. One sprite is taken every cycle unless the output stalls. An input
// transfer reaches output valid through the seven-stage polynomial sine pipeline, then the
// skew, scale, offset and sum stages. The whole pipeline stalls while the output waits.
`timescale 1ns / 1ps
`default_nettype none
`include "sprite_affine_transform_build_macros.svh"
module sprite_affine_transform_build (
	input  wire logic   clk,
	input  wire logic   arst_n,
	satb_in_if.sink     in_ch,
	satb_out_if.source  out_ch
);
	localparam int D = satb_pkg::PIPE_DEPTH;
	localparam int SD = 7;
	localparam int AB = satb_pkg::ANGLE_BITS;

	logic en;
	logic [D-1:0] vld_q;
	logic [AB-1:0] ang;
	logic [1:0] quad;
	logic [31:0] t, tc, st, sc;
	logic [1:0] quad_q [SD];
	satb_pkg::in_item_t item_q [SD];
	logic signed [31:0] s, c;

	// pipeline advances unless a finished result is stalled
	assign en = !vld_q[D-1] || out_ch.ready;
	assign in_ch.ready = en;

	always_comb begin
		ang  = in_ch.data.angle[AB-1:0];
		quad = ang[AB-1:AB-2];
		t    = 32'({ang[AB-3:0]}) << (32 - AB);
		tc   = 32'(satb_pkg::Q30_ONE) - t;
	end

	satb_sine u_sin (.clk(clk), .en(en), .t(t), .s(st));
	satb_sine u_cos (.clk(clk), .en(en), .t(tc), .s(sc));

	// item and quadrant delay line alongside the sine pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			quad_q[0] <= quad;
			item_q[0] <= in_ch.data;
			for (int i = 1; i < SD; i++) begin
				quad_q[i] <= quad_q[i-1];
				item_q[i] <= item_q[i-1];
			end
		end
	end

	always_comb begin
		case (quad_q[SD-1])
			2'd0:    begin s = st;  c = sc;  end
			2'd1:    begin s = sc;  c = -st; end
			2'd2:    begin s = -st; c = -sc; end
			default: begin s = -sc; c = st;  end
		endcase
	end

	satb_matrix u_mat (.clk(clk), .en(en), .sn(s), .cs(c), .item(item_q[SD-1]),
		.res(out_ch.data));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[D-2:0], in_ch.valid};
		end
	end

	assign out_ch.valid = vld_q[D-1];

	`SAT_ASSERT(a_ready_when_empty, !vld_q[D-1] |-> in_ch.ready, "ready low with empty out")
	`SAT_ASSERT_NEXT(a_hold_stall, out_ch.valid && !out_ch.ready, out_ch.valid,
		"result dropped under stall")
	`SAT_ASSERT_NEXT(a_fill, in_ch.valid && in_ch.ready, vld_q[0], "transfer not tracked")
endmodule
`default_nettype wire
